// ----- rtl/core/abm_pkg.sv -----
`default_nettype none
package abm_pkg;

  // store geometry
  localparam int MAX_BITS    = 1024;
  localparam int WORD_BITS   = 8;
  localparam int STORE_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = $clog2(STORE_WORDS);
  localparam int WSEL_W      = $clog2(WORD_BITS);
  localparam int INDEX_W     = 10;
  localparam int LEN_W       = 11;
  localparam int INDEX_SPAN  = 1024;
  localparam int LEN_CAP     = (MAX_BITS < INDEX_SPAN) ? MAX_BITS : INDEX_SPAN;

  localparam logic [LEN_W-1:0] ACTIVE_RESET = LEN_W'(1024);

  // command codes
  localparam logic [2:0] FN_SET = 3'd0;
  localparam logic [2:0] FN_CLR = 3'd1;
  localparam logic [2:0] FN_TST = 3'd2;
  localparam logic [2:0] FN_FFS = 3'd3;
  localparam logic [2:0] FN_FFZ = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RESULT
  } state_t;

  // request to the word unit
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 row_ok;
    logic [2:0]           func;
    logic [WSEL_W-1:0]    bsel;
    logic [WADDR_W-1:0]   addr;
    logic [LEN_W-1:0]     len;
  } wu_req_t;

  // answer from the word unit
  typedef struct packed {
    logic                 hit;
    logic [WSEL_W-1:0]    hit_pos;
    logic                 last;
    logic                 bit_val;
    logic [WORD_BITS-1:0] word_new;
  } wu_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/abm_ram.sv -----
`default_nettype none
module abm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/abm_word_unit.sv -----
`default_nettype none
module abm_word_unit (
  input  wire abm_pkg::wu_req_t req,
  output abm_pkg::wu_rsp_t      rsp
);
  import abm_pkg::*;

  logic [WORD_BITS-1:0] w;
  logic [WORD_BITS-1:0] srch;
  logic [WADDR_W:0]     nxt;

  // find first match within the length, modify one bit, flag the last word
  always_comb begin
    w    = req.row_ok ? req.word : '0;
    srch = (req.func == FN_FFZ) ? ~w : w;
    nxt  = {1'b0, req.addr} + (WADDR_W + 1)'(1);
    rsp.hit     = 1'b0;
    rsp.hit_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (srch[b] && (LEN_W'({req.addr, WSEL_W'(b)}) < req.len)) begin
        rsp.hit     = 1'b1;
        rsp.hit_pos = WSEL_W'(b);
      end
    end
    rsp.last           = LEN_W'({nxt, {WSEL_W{1'b0}}}) >= req.len;
    rsp.bit_val        = w[req.bsel];
    rsp.word_new       = w;
    rsp.word_new[req.bsel] = (req.func == FN_SET);
  end

endmodule
`default_nettype wire

// ----- rtl/core/allocation_bitmap_find_first_unit.sv -----
`default_nettype none
// Channel  Dir  Width  Contents
// s_axis   in   16     command beat: func, bit_index
// m_axis   out  16     result beat: ok, bit_value, found_index
// cfg      in   11     active_bits write, taken every cycle
//
// Set, clear and test pass from accept through the evaluate state to the result
// state; a rejected index or an unknown command skips the store and goes to
// the result state. A search reads the store one 8-bit word at a time, over up to
// 128 words; the single read port of the store sets this.
// Reset clears 128 row valid flops at once, so the store reads as zero.
// s_axis_tready is high only between commands; a waiting result beat holds
// the sequencer in its result state until taken.
module allocation_bitmap_find_first_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [2:0] func, [12:3] bit_index, [15:13] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [0] ok, [1] bit_value, [11:2] found_index
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data        // active_bits
);
  import abm_pkg::*;

  state_t state, state_next;

  logic [LEN_W-1:0]       active_bits;
  logic [LEN_W-1:0]       len;
  logic [2:0]             func;
  logic [WSEL_W-1:0]      bsel;
  logic [WADDR_W-1:0]     addr, addr_next;
  logic [STORE_WORDS-1:0] row_valid;
  logic                   rowv;
  logic                   store_we;
  logic [WORD_BITS-1:0]   rdata;

  logic                   res_ok, res_ok_next;
  logic                   res_bv, res_bv_next;
  logic [INDEX_W-1:0]     res_fi, res_fi_next;

  logic                   in_beat;
  logic                   out_free;
  logic [2:0]             in_func;
  logic [INDEX_W-1:0]     in_idx;
  logic                   go_eval;
  logic                   is_srch;
  logic                   scan_on;

  wu_req_t                wreq;
  wu_rsp_t                wrsp;

  assign in_func  = s_axis_tdata[2:0];
  assign in_idx   = s_axis_tdata[12:3];
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign len      = (active_bits > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : active_bits;
  assign is_srch  = (func == FN_FFS) || (func == FN_FFZ);
  assign scan_on  = is_srch && !wrsp.hit && !wrsp.last;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  // decide whether an accepted command needs the store
  always_comb begin
    case (in_func) inside
      FN_SET, FN_CLR, FN_TST: go_eval = {1'b0, in_idx} < len;
      FN_FFS, FN_FFZ:         go_eval = len != '0;
      default:                go_eval = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_beat) state_next = go_eval ? ST_EVAL : ST_RESULT;
      ST_EVAL:   if (!scan_on) state_next = ST_RESULT;
      ST_RESULT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    addr_next   = addr;
    store_we    = 1'b0;
    res_ok_next = res_ok;
    res_bv_next = res_bv;
    res_fi_next = res_fi;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          res_ok_next = 1'b0;
          res_bv_next = 1'b0;
          res_fi_next = '0;
          case (in_func) inside
            FN_FFS, FN_FFZ: addr_next = '0;
            default:        addr_next = in_idx[INDEX_W-1:WSEL_W];
          endcase
        end
      end
      ST_EVAL: begin
        case (func) inside
          FN_SET, FN_CLR: begin
            store_we    = 1'b1;
            res_ok_next = 1'b1;
          end
          FN_TST: begin
            res_ok_next = 1'b1;
            res_bv_next = wrsp.bit_val;
          end
          default: begin
            if (wrsp.hit) begin
              res_ok_next = 1'b1;
              res_fi_next = INDEX_W'({addr, wrsp.hit_pos});
            end else if (!wrsp.last) begin
              addr_next = addr + WADDR_W'(1);
            end
          end
        endcase
      end
      ST_RESULT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active_bits   <= ACTIVE_RESET;
      row_valid     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        active_bits <= cfg_data;
      end
      if (store_we) begin
        row_valid[addr] <= 1'b1;
      end
      if (state == ST_RESULT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr   <= addr_next;
    rowv   <= row_valid[addr_next];
    res_ok <= res_ok_next;
    res_bv <= res_bv_next;
    res_fi <= res_fi_next;
    if (in_beat) begin
      func <= in_func;
      bsel <= in_idx[WSEL_W-1:0];
    end
    if (state == ST_RESULT && out_free) begin
      m_axis_tdata <= {4'b0, res_fi, res_bv, res_ok};
    end
  end

  // shared word unit
  always_comb begin
    wreq.word   = rdata;
    wreq.row_ok = rowv;
    wreq.func   = func;
    wreq.bsel   = bsel;
    wreq.addr   = addr;
    wreq.len    = len;
  end

  abm_word_unit u_word (
    .req (wreq),
    .rsp (wrsp)
  );

  abm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (addr),
    .wdata (wrsp.word_new),
    .raddr (addr_next),
    .rdata (rdata)
  );

  // a found index or a set bit value only comes with success
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[11:2] != '0) |-> m_axis_tdata[0])
    else $error("found_index set on a failed result");

  a_bv_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
    else $error("bit_value set on a failed result");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_axis_tready)
    else $error("command taken while busy");

  a_row_mark: assert property (@(posedge clk) disable iff (rst)
    store_we |=> row_valid[$past(addr)])
    else $error("written row not marked valid");

endmodule
`default_nettype wire
